/* hdl/gtl_pkg.sv */
// Package: shared types, codes and the character mapping table of the Greek to Latin transliterator.
`default_nettype none

package gtl_pkg;

	// Item kinds on the Greek channel
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Held-letter codes
	localparam logic [2:0] HELD_NONE = 3'd0;
	localparam logic [2:0] HELD_M_UP = 3'd1;
	localparam logic [2:0] HELD_N_UP = 3'd2;
	localparam logic [2:0] HELD_M_LO = 3'd3;
	localparam logic [2:0] HELD_N_LO = 3'd4;
	localparam logic [2:0] HELD_LAST = HELD_N_LO;

	localparam logic [7:0] CHR_APOS  = 8'd39;
	localparam logic [7:0] CHR_QUOTE = 8'd34;

	// Greek bytes that are held (mu, nu) or join with a held letter (pi, tau)
	localparam logic [7:0] GR_PI_UP  = 8'd208;
	localparam logic [7:0] GR_PI_LO  = 8'd240;
	localparam logic [7:0] GR_TAU_UP = 8'd212;
	localparam logic [7:0] GR_TAU_LO = 8'd244;
	localparam logic [7:0] GR_MU_UP  = 8'd204;
	localparam logic [7:0] GR_NU_UP  = 8'd205;
	localparam logic [7:0] GR_MU_LO  = 8'd236;
	localparam logic [7:0] GR_NU_LO  = 8'd237;

	localparam int ROW_LEN = 25;
	localparam logic [8*ROW_LEN-1:0] UPPER_ROW = "AVGDEZH8IKLMNQOPR-STUFXYW";
	localparam logic [8*ROW_LEN-1:0] LOWER_ROW = "avgdezh8iklmnqoprsstufxyw";
	localparam logic [7:0] UPPER_BASE = 8'd193;
	localparam logic [7:0] LOWER_BASE = 8'd225;

	// Up to three mapped characters; a zero byte means none
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} map_t;

	function automatic map_t map_byte(input logic [7:0] c);
		map_t       m;
		logic [4:0] i;
		m = '{b0: c, b1: 8'd0, b2: 8'd0};
		i = 5'd0;
		if (c >= UPPER_BASE && c <= UPPER_BASE + 8'd24) begin
			i = 5'(c - UPPER_BASE);
			m.b0 = UPPER_ROW[(ROW_LEN - 1 - int'(i)) * 8 +: 8];
		end
		if (c >= LOWER_BASE && c <= LOWER_BASE + 8'd24) begin
			i = 5'(c - LOWER_BASE);
			m.b0 = LOWER_ROW[(ROW_LEN - 1 - int'(i)) * 8 +: 8];
		end
		case (c)
			8'd182: m = '{CHR_APOS, "A", 8'd0};
			8'd184: m = '{CHR_APOS, "E", 8'd0};
			8'd185: m = '{CHR_APOS, "H", 8'd0};
			8'd186: m = '{CHR_APOS, "I", 8'd0};
			8'd188: m = '{CHR_APOS, "O", 8'd0};
			8'd190: m = '{CHR_APOS, "Y", 8'd0};
			8'd191: m = '{CHR_APOS, "W", 8'd0};
			8'd220: m = '{"a", CHR_APOS, 8'd0};
			8'd221: m = '{"e", CHR_APOS, 8'd0};
			8'd222: m = '{"h", CHR_APOS, 8'd0};
			8'd223: m = '{"i", CHR_APOS, 8'd0};
			8'd252: m = '{"o", CHR_APOS, 8'd0};
			8'd253: m = '{"u", CHR_APOS, 8'd0};
			8'd254: m = '{"w", CHR_APOS, 8'd0};
			8'd218: m = '{"I", CHR_QUOTE, 8'd0};
			8'd219: m = '{"Y", CHR_QUOTE, 8'd0};
			8'd250: m = '{"i", CHR_QUOTE, 8'd0};
			8'd251: m = '{"u", CHR_QUOTE, 8'd0};
			8'd192: m = '{"i", CHR_APOS, CHR_QUOTE};
			8'd224: m = '{"u", CHR_APOS, CHR_QUOTE};
			8'd238: m = '{"k", "s", 8'd0};
			8'd248: m = '{"p", "s", 8'd0};
			8'd206: m = '{"K", "S", 8'd0};
			8'd216: m = '{"P", "S", 8'd0};
			default: ;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] held_char(input logic [2:0] h);
		logic [7:0] r;
		case (h)
			HELD_M_UP: r = "M";
			HELD_N_UP: r = "N";
			HELD_M_LO: r = "m";
			HELD_N_LO: r = "n";
			default:   r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] hold_code(input logic [7:0] c);
		logic [2:0] r;
		case (c)
			GR_MU_UP: r = HELD_M_UP;
			GR_NU_UP: r = HELD_N_UP;
			GR_MU_LO: r = HELD_M_LO;
			GR_NU_LO: r = HELD_N_LO;
			default:  r = HELD_NONE;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/gtl_greek_if.sv */
// Interface: Greek input channel (valid/ready with kind and byte).
`default_nettype none

interface gtl_greek_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] in_byte;

	modport source (output valid, output kind, output in_byte, input ready);
	modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

`default_nettype wire

/* hdl/gtl_latin_if.sv */
// Interface: Latin output channel (valid/ready with byte and last mark).
`default_nettype none

interface gtl_latin_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

/* hdl/greek_to_latin_transliterator.sv */
// Top level: ISO-8859-7 Greek to Latin transliterator with M+P and N+T joining.
//
// Usage
//   greek: one transfer per input item. kind = data carries an ISO-8859-7 byte;
//          kind = end of stream flushes a held M or N (in_byte ignored).
//   latin: one transfer per output character; last marks the final character
//          caused by one input item. Items that cause nothing (byte 0, a held
//          M/N, end of stream with nothing held) give no transfer at all.
// Path: with the result register free, an item transferred on greek is first
//   captured in the input register, then loaded into the result register,
//   from which its first character is offered on latin.
// Flow: an item causing n characters (n = 0..4) holds the result register
//   while they are sent, one character per cycle while latin is ready; the
//   single-byte result channel sets the sustained rate. Greek items that cause
//   nothing pass at one per cycle while the result register is free.
// Stalls: the input register takes one item while the result register is
//   still sending; while latin is stalled the result register holds, the
//   next item waits in the input register and greek.ready drops.
// Reset: arst_n clears both valid flags and the held letter; no transfers are
//   offered until new items arrive.
`default_nettype none

module greek_to_latin_transliterator (
	input  wire          clk,
	input  wire          arst_n,
	gtl_greek_if.sink    greek,
	gtl_latin_if.source  latin
);
	import gtl_pkg::*;

	// Input register
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;

	// Held letter
	logic [2:0] pend_q;

	// Result register: up to four characters, sent one per cycle while latin is ready
	logic       res_valid_s2;
	logic [7:0] res_bytes_s2 [4];
	logic [2:0] res_cnt_s2;
	logic [1:0] res_idx_s2;

	// Combinational result of the item in the input register
	logic [2:0] held;
	logic       join_m;
	logic       join_n;
	logic [7:0] head;
	logic [2:0] next_pend;
	map_t       mapped;
	logic [1:0] mapped_cnt;
	logic [7:0] list [4];
	logic [2:0] n_res;

	logic is_last;
	logic greek_fire;
	logic latin_fire;
	logic load;

	always_comb begin
		held   = (pend_q > HELD_LAST) ? HELD_NONE : pend_q;
		join_m = (held == HELD_M_UP || held == HELD_M_LO) &&
		         (byte_s1 == GR_PI_UP || byte_s1 == GR_PI_LO);
		join_n = (held == HELD_N_UP || held == HELD_N_LO) &&
		         (byte_s1 == GR_TAU_UP || byte_s1 == GR_TAU_LO);
		mapped    = '{b0: 8'd0, b1: 8'd0, b2: 8'd0};
		head      = held_char(held);
		next_pend = HELD_NONE;
		if (kind_s1 == KIND_DATA) begin
			if (join_m) begin
				head = (held == HELD_M_UP) ? 8'("B") : 8'("b");
			end else if (join_n) begin
				head = (held == HELD_N_UP) ? 8'("D") : 8'("d");
			end else begin
				next_pend = hold_code(byte_s1);
				if (next_pend == HELD_NONE) begin
					mapped = map_byte(byte_s1);
				end
			end
		end
		// Mapped characters always form a prefix, so only the head needs packing
		mapped_cnt = 2'(mapped.b0 != 8'd0) + 2'(mapped.b1 != 8'd0) +
		             2'(mapped.b2 != 8'd0);
		if (head != 8'd0) begin
			list  = '{head, mapped.b0, mapped.b1, mapped.b2};
			n_res = 3'd1 + {1'b0, mapped_cnt};
		end else begin
			list  = '{mapped.b0, mapped.b1, mapped.b2, 8'd0};
			n_res = {1'b0, mapped_cnt};
		end
	end

	assign is_last    = ({1'b0, res_idx_s2} == res_cnt_s2 - 3'd1);
	assign latin_fire = latin.valid && latin.ready;
	assign greek_fire = greek.valid && greek.ready;
	// Move the item on when the result register is empty or frees this cycle
	assign load       = valid_s1 && (!res_valid_s2 || (latin.ready && is_last));
	assign greek.ready = !valid_s1 || load;

	assign latin.valid    = res_valid_s2;
	assign latin.out_byte = res_bytes_s2[res_idx_s2];
	assign latin.last     = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			pend_q       <= HELD_NONE;
			res_valid_s2 <= 1'b0;
			res_idx_s2   <= 2'd0;
		end else begin
			if (greek_fire) begin
				valid_s1 <= 1'b1;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				pend_q       <= next_pend;
				res_valid_s2 <= (n_res != 3'd0);
				res_idx_s2   <= 2'd0;
			end else if (latin_fire) begin
				if (is_last) begin
					res_valid_s2 <= 1'b0;
				end else begin
					res_idx_s2 <= res_idx_s2 + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (greek_fire) begin
			kind_s1 <= greek.kind;
			byte_s1 <= greek.in_byte;
		end
		if (load) begin
			res_bytes_s2 <= list;
			res_cnt_s2   <= n_res;
		end
	end

	// A held result always has one to four characters
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> (res_cnt_s2 != 3'd0 && res_cnt_s2 <= 3'd4))
		else $error("result count out of range");

	// The send index never runs past the count
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> ({1'b0, res_idx_s2} < res_cnt_s2))
		else $error("result index past count");

	// A zero character is never sent
	a_no_zero: assert property (@(posedge clk) disable iff (!arst_n)
		latin.valid |-> (latin.out_byte != 8'd0))
		else $error("zero character offered");

	// Only defined held-letter codes are stored
	a_pend_code: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= HELD_LAST)
		else $error("undefined held-letter code");

endmodule

`default_nettype wire

/* dv/tb_greek_to_latin_transliterator.sv */
// Testbench: self-checking random and directed test of the Greek to Latin transliterator.
`timescale 1ns / 100ps

module tb_greek_to_latin_transliterator;
	import gtl_pkg::*;

	// Scoreboard: tracks the held M/N and queues the Latin characters that each
	// accepted Greek item should produce, then checks results in order.
	class latin_scoreboard;
		typedef struct packed {
			logic [7:0] chr;
			logic       last;
		} latin_char_t;

		latin_char_t expected_chars[$];
		logic [2:0]  held;
		int          errors;
		string       upper_greek;
		string       lower_greek;

		function new();
			held        = HELD_NONE;
			errors      = 0;
			upper_greek = "AVGDEZH8IKLMNQOPR-STUFXYW";
			lower_greek = "avgdezh8iklmnqoprsstufxyw";
		endfunction

		function logic [7:0] letter_of(logic [2:0] h);
			case (h)
				HELD_M_UP: return "M";
				HELD_N_UP: return "N";
				HELD_M_LO: return "m";
				HELD_N_LO: return "n";
				default:   return 8'd0;
			endcase
		endfunction

		// Work out the characters caused by one accepted Greek item
		function void note_input(logic kind, logic [7:0] c);
			logic [7:0]  chars[$];
			logic [23:0] t;
			logic [2:0]  next_held;
			chars = {};
			if (kind == KIND_END) begin
				if (held != HELD_NONE)
					chars.push_back(letter_of(held));
				held = HELD_NONE;
			end else if ((held == HELD_M_UP || held == HELD_M_LO) &&
					(c == GR_PI_UP || c == GR_PI_LO)) begin
				chars.push_back(held == HELD_M_UP ? "B" : "b");
				held = HELD_NONE;
			end else if ((held == HELD_N_UP || held == HELD_N_LO) &&
					(c == GR_TAU_UP || c == GR_TAU_LO)) begin
				chars.push_back(held == HELD_N_UP ? "D" : "d");
				held = HELD_NONE;
			end else begin
				case (c)
					GR_MU_UP: next_held = HELD_M_UP;
					GR_NU_UP: next_held = HELD_N_UP;
					GR_MU_LO: next_held = HELD_M_LO;
					GR_NU_LO: next_held = HELD_N_LO;
					default:  next_held = HELD_NONE;
				endcase
				if (held != HELD_NONE)
					chars.push_back(letter_of(held));
				if (next_held == HELD_NONE) begin
					t = {c, 16'h0000};
					if (c >= 8'd193 && c <= 8'd217)
						t[23:16] = upper_greek[int'(c) - 193];
					if (c >= 8'd225 && c <= 8'd249)
						t[23:16] = lower_greek[int'(c) - 225];
					case (c)
						// capitals with tonos: accent mark first
						8'd182: t = {CHR_APOS, "A", 8'd0};
						8'd184: t = {CHR_APOS, "E", 8'd0};
						8'd185: t = {CHR_APOS, "H", 8'd0};
						8'd186: t = {CHR_APOS, "I", 8'd0};
						8'd188: t = {CHR_APOS, "O", 8'd0};
						8'd190: t = {CHR_APOS, "Y", 8'd0};
						8'd191: t = {CHR_APOS, "W", 8'd0};
						// small letters with tonos: accent mark after
						8'd220: t = {"a", CHR_APOS, 8'd0};
						8'd221: t = {"e", CHR_APOS, 8'd0};
						8'd222: t = {"h", CHR_APOS, 8'd0};
						8'd223: t = {"i", CHR_APOS, 8'd0};
						8'd252: t = {"o", CHR_APOS, 8'd0};
						8'd253: t = {"u", CHR_APOS, 8'd0};
						8'd254: t = {"w", CHR_APOS, 8'd0};
						// dialytika
						8'd218: t = {"I", CHR_QUOTE, 8'd0};
						8'd219: t = {"Y", CHR_QUOTE, 8'd0};
						8'd250: t = {"i", CHR_QUOTE, 8'd0};
						8'd251: t = {"u", CHR_QUOTE, 8'd0};
						8'd192: t = {"i", CHR_APOS, CHR_QUOTE};
						8'd224: t = {"u", CHR_APOS, CHR_QUOTE};
						// xi and psi become pairs
						8'd238: t = {"k", "s", 8'd0};
						8'd248: t = {"p", "s", 8'd0};
						8'd206: t = {"K", "S", 8'd0};
						8'd216: t = {"P", "S", 8'd0};
						default: ;
					endcase
					for (int i = 2; i >= 0; i--)
						if (t[i*8 +: 8] != 8'd0)
							chars.push_back(t[i*8 +: 8]);
				end
				held = next_held;
			end
			foreach (chars[i])
				expected_chars.push_back('{chr: chars[i], last: (i == chars.size() - 1)});
		endfunction

		// Compare one Latin transfer with the oldest expectation
		function void check_result(logic [7:0] chr, logic last);
			latin_char_t want;
			if (expected_chars.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected character %h last %b", $time, chr, last);
			end else begin
				want = expected_chars.pop_front();
				if (want.chr !== chr || want.last !== last) begin
					errors++;
					if (errors <= 10)
						$display("%0t: mismatch: expected %h last %b, got %h last %b",
							$time, want.chr, want.last, chr, last);
				end
			end
		endfunction
	endclass

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int          RANDOM_ITEMS = 410;
	localparam int          QUIET_TAIL   = 60;

	logic            clk;
	logic            arst_n;
	bit              gaps_on;
	int unsigned     cycle_count;
	latin_scoreboard sb;

	gtl_greek_if greek();
	gtl_latin_if latin();

	greek_to_latin_transliterator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.greek  (greek),
		.latin  (latin)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: give up well beyond the slowest legal run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Check every Latin transfer; values sampled here are those before the edge
	always @(posedge clk) begin
		if (arst_n && latin.valid && latin.ready)
			sb.check_result(latin.out_byte, latin.last);
	end

	// Latin sink: hold ready low in random bursts while gaps are on, otherwise
	// keep it high
	initial begin
		latin.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (gaps_on && $urandom_range(0, 3) == 0) begin
				latin.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			latin.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Offer one Greek item, with an optional gap first, and hold it until the
	// transfer; valid is left high so back-to-back items need no bubble
	task automatic send_item(input logic k, input logic [7:0] b);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			greek.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		greek.valid   <= 1'b1;
		greek.kind    <= k;
		greek.in_byte <= b;
		do @(posedge clk); while (!greek.ready);
		sb.note_input(k, b);
	endtask

	// Stop sending and let every outstanding character come out
	task automatic hold_until_drained();
		greek.valid <= 1'b0;
		while (sb.expected_chars.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Directed items: {kind, byte}
	logic [8:0] directed[$] = '{
		{KIND_DATA, 8'd0},       // byte 0 gives nothing
		{KIND_DATA, 8'd255},     // passes through
		{KIND_DATA, 8'd193},     // first capital of the table
		{KIND_DATA, 8'd249},     // last small letter of the table
		{KIND_DATA, 8'd182},     // accent mark before the letter
		{KIND_DATA, 8'd220},     // accent mark after the letter
		{KIND_DATA, 8'd218},     // dialytika
		{KIND_DATA, 8'd192},     // three characters
		{KIND_DATA, 8'd206},     // KS pair
		{KIND_DATA, GR_MU_UP},   // M + P joins to B
		{KIND_DATA, GR_PI_UP},
		{KIND_DATA, GR_MU_LO},   // m + p joins to b
		{KIND_DATA, GR_PI_LO},
		{KIND_DATA, GR_NU_UP},   // N + t joins to D, case of the held letter
		{KIND_DATA, GR_TAU_LO},
		{KIND_DATA, GR_NU_LO},   // n + T joins to d
		{KIND_DATA, GR_TAU_UP},
		{KIND_DATA, GR_MU_UP},   // held M followed by N: M out, N held
		{KIND_DATA, GR_NU_UP},
		{KIND_DATA, 8'd0},       // held letter followed by byte 0
		{KIND_DATA, GR_MU_LO},   // end of stream flushes the held letter
		{KIND_END,  8'hA5},
		{KIND_END,  8'h5A},      // end of stream with nothing held
		{KIND_DATA, GR_MU_UP},   // held letter plus three characters: four out
		{KIND_DATA, 8'd224}
	};

	initial begin
		logic       k;
		logic [7:0] b;
		int         r;

		sb          = new();
		gaps_on     = 1'b1;
		arst_n      = 1'b0;
		greek.valid   = 1'b0;
		greek.kind    = KIND_DATA;
		greek.in_byte = 8'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i][8], directed[i][7:0]);
		hold_until_drained();

		// Random text: mostly Greek with plenty of M/N and P/T to reach the
		// joining cases, some byte 0, stray ends of stream and raw bytes
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			if (i >= RANDOM_ITEMS - QUIET_TAIL)
				gaps_on = 1'b0;
			if (i == RANDOM_ITEMS / 2)
				hold_until_drained();
			r = $urandom_range(0, 99);
			case ($urandom_range(0, 3))
				0: b = (r < 25) ? GR_MU_UP : GR_PI_UP;
				1: b = (r < 25) ? GR_NU_UP : GR_TAU_UP;
				2: b = (r < 25) ? GR_MU_LO : GR_PI_LO;
				default: b = (r < 25) ? GR_NU_LO : GR_TAU_LO;
			endcase
			if (r >= 45 && r < 85)
				b = 8'($urandom_range(182, 254));
			else if (r >= 85 && r < 90)
				b = 8'd0;
			else if (r >= 90)
				b = 8'($urandom_range(0, 255));
			k = ($urandom_range(0, 19) == 0) ? KIND_END : KIND_DATA;
			if (k == KIND_END)
				b = 8'($urandom_range(0, 255));
			send_item(k, b);
		end

		// Flush whatever is still held, then wait for the tail to come out
		send_item(KIND_END, 8'd0);
		greek.valid <= 1'b0;
		while (sb.expected_chars.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (sb.errors == 0 && sb.expected_chars.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
